// ===== design/olm_pkg.sv =====
// Shared types and codes for the orthographic lens point mapper.
package olm_pkg;

    typedef enum logic [1:0] {
        CFG_FOCAL_X  = 2'd0,
        CFG_FOCAL_Y  = 2'd1,
        CFG_CENTER_X = 2'd2,
        CFG_CENTER_Y = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_SAT     = 2'd2
    } t_status;

    localparam logic ACT_PROJECT   = 1'b0;
    localparam logic ACT_UNPROJECT = 1'b1;

    typedef struct packed {
        logic act;
        logic neg_x;
        logic neg_y;
        logic outside;
    } t_flags;

endpackage

// ===== design/orthographic_lens_point_mapper.sv =====
// Orthographic lens point mapper top level: pipeline of arithmetic cells.
// Throughput one point per cycle while the skid entry is empty, set by the bit-per-cell divider and root rows.
// The input stays open while one finished result waits; a two-entry output buffer stalls it.
// Synchronous active-low reset clears valid bits and restores focal 1.0, centre 0.
module orthographic_lens_point_mapper #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  olm_pkg::t_cfg_index           i_cfg_index,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output olm_pkg::t_status              o_status
);
    import olm_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int FL_W   = $bits(t_flags);
    localparam int SA_W   = FL_W + 2 * (W + 1);
    localparam int SS_W   = FL_W + 2 * W;
    localparam logic [W-1:0]   ONE_Q  = {{(W-1){1'b0}}, 1'b1} << F;
    localparam logic [2*W-1:0] ONE_Q2 = {{(2*W-1){1'b0}}, 1'b1} << (2 * F);
    localparam logic signed [2*W+1:0] LIM_HI = {{(W+3){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [2*W+1:0] LIM_LO = {{(W+3){1'b1}}, {(W-1){1'b0}}};

    logic [W-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y;
    logic         w_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= ONE_Q;
            r_focal_y  <= ONE_Q;
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                default:      r_focal_x  <= r_focal_x;
            endcase
        end
    end

    // Stage 1: centre (unproject only) and take magnitudes
    logic [W:0]   w_ax, w_ay, w_ux, w_uy, w_sx, w_sy, w_mx, w_my;
    t_flags       w_f1;
    logic         r1_v;
    t_flags       r1_f;
    logic [W:0]   r1_mx, r1_my;

    always_comb begin
        w_ax = {i_coord_x[W-1], i_coord_x};
        w_ay = {i_coord_y[W-1], i_coord_y};
        w_ux = w_ax - {r_center_x[W-1], r_center_x};
        w_uy = w_ay - {r_center_y[W-1], r_center_y};
        w_sx = (i_action == ACT_UNPROJECT) ? w_ux : w_ax;
        w_sy = (i_action == ACT_UNPROJECT) ? w_uy : w_ay;
        w_mx = w_sx[W] ? (~w_sx + 1'b1) : w_sx;
        w_my = w_sy[W] ? (~w_sy + 1'b1) : w_sy;
        w_f1.act     = i_action;
        w_f1.neg_x   = w_sx[W];
        w_f1.neg_y   = w_sy[W];
        w_f1.outside = (i_action == ACT_UNPROJECT)
                       && ((r_focal_y == '0) || (w_mx >= {1'b0, r_focal_x}));
    end

    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_f  <= w_f1;
            r1_mx <= w_mx;
            r1_my <= w_my;
        end
    end

    // Stage 2: y scale product for unproject
    logic         r2_v;
    t_flags       r2_f;
    logic [W:0]   r2_mx, r2_my;
    logic [2*W:0] r2_pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_f  <= r1_f;
            r2_mx <= r1_mx;
            r2_my <= r1_my;
            r2_pv <= {{W{1'b0}}, r1_my} * {{(W+1){1'b0}}, r_focal_x};
        end
    end

    // Divide by focal y
    logic [W:0]      w_a_top;
    t_flags          w_fa;
    logic [W-1:0]    w_a_rem [1];
    logic [W-1:0]    w_a_num [1];
    logic [W-1:0]    w_a_q   [1];
    logic [SA_W-1:0] w_a_side_in, w_a_side_out;
    logic            w_a_v;

    always_comb begin
        w_a_top       = r2_pv[2*W:W];
        w_fa          = r2_f;
        w_fa.outside  = r2_f.outside
                        || (r2_f.act && (w_a_top >= {1'b0, r_focal_y}));
        w_a_rem[0]    = w_a_top[W-1:0];
        w_a_num[0]    = r2_pv[W-1:0];
        w_a_side_in   = {w_fa, r2_mx, r2_my};
    end

    olm_div_chain #(
        .LANES (1),
        .REM_W (W),
        .NUM_W (W),
        .SIDE_W(SA_W)
    ) u_div_fy (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r2_v),
        .i_side (w_a_side_in),
        .i_den  (r_focal_y),
        .i_rem  (w_a_rem),
        .i_num  (w_a_num),
        .o_valid(w_a_v),
        .o_side (w_a_side_out),
        .o_q    (w_a_q)
    );

    // Stage 3: pick the pair to square
    t_flags       w_fa_o, w_f3;
    logic [W:0]   w_a_mx, w_a_my;
    logic         r3_v;
    t_flags       r3_f;
    logic [W-1:0] r3_ex, r3_ey;

    always_comb begin
        {w_fa_o, w_a_mx, w_a_my} = w_a_side_out;
        w_f3         = w_fa_o;
        w_f3.outside = w_fa_o.outside || (w_fa_o.act && (w_a_q[0] >= r_focal_x));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= w_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_f  <= w_f3;
            r3_ex <= w_a_mx[W-1:0];
            r3_ey <= (w_fa_o.act == ACT_UNPROJECT) ? w_a_q[0] : w_a_my[W-1:0];
        end
    end

    // Stage 4: squares
    logic           r4_v;
    t_flags         r4_f;
    logic [W-1:0]   r4_ex, r4_ey;
    logic [2*W-1:0] r4_sx, r4_sy, r4_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_f  <= r3_f;
            r4_ex <= r3_ex;
            r4_ey <= r3_ey;
            r4_sx <= {{W{1'b0}}, r3_ex} * {{W{1'b0}}, r3_ex};
            r4_sy <= {{W{1'b0}}, r3_ey} * {{W{1'b0}}, r3_ey};
            r4_f2 <= {{W{1'b0}}, r_focal_x} * {{W{1'b0}}, r_focal_x};
        end
    end

    // Stage 5: radicand
    logic [2*W:0]   w_r2;
    t_flags         w_f5;
    logic           r5_v;
    t_flags         r5_f;
    logic [W-1:0]   r5_ex, r5_ey;
    logic [2*W-1:0] r5_rad;

    always_comb begin
        w_r2         = {1'b0, r4_sx} + {1'b0, r4_sy};
        w_f5         = r4_f;
        w_f5.outside = r4_f.outside || (r4_f.act && (w_r2 >= {1'b0, r4_f2}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_f   <= w_f5;
            r5_ex  <= r4_ex;
            r5_ey  <= r4_ey;
            r5_rad <= (r4_f.act == ACT_UNPROJECT) ? (r4_f2 - w_r2[2*W-1:0])
                                                   : (w_r2[2*W-1:0] + ONE_Q2);
        end
    end

    // Square root
    logic [SS_W-1:0] w_s_side_out;
    logic            w_s_v;
    logic [W-1:0]    w_root;

    olm_sqrt_chain #(
        .ROOT_W(W),
        .SIDE_W(SS_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r5_v),
        .i_side ({r5_f, r5_ex, r5_ey}),
        .i_rad  (r5_rad),
        .o_valid(w_s_v),
        .o_side (w_s_side_out),
        .o_root (w_root)
    );

    // Stage 6: numerators
    t_flags         w_fs;
    logic [W-1:0]   w_s_ex, w_s_ey;
    logic           r6_v;
    t_flags         r6_f;
    logic [W-1:0]   r6_den;
    logic [2*W-1:0] r6_nx, r6_ny;

    assign {w_fs, w_s_ex, w_s_ey} = w_s_side_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= w_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_f   <= w_fs;
            r6_den <= w_root;
            if (w_fs.act == ACT_UNPROJECT) begin
                r6_nx <= {{W{1'b0}}, w_s_ex} << F;
                r6_ny <= {{W{1'b0}}, w_s_ey} << F;
            end else begin
                r6_nx <= {{W{1'b0}}, w_s_ex} * {{W{1'b0}}, r_focal_x};
                r6_ny <= {{W{1'b0}}, w_s_ey} * {{W{1'b0}}, r_focal_y};
            end
        end
    end

    // Final divide, both coordinates
    logic [W-1:0]    w_d_rem [2];
    logic [2*W-1:0]  w_d_num [2];
    logic [2*W-1:0]  w_d_q   [2];
    logic [FL_W-1:0] w_d_side;
    logic            w_d_v;

    assign w_d_rem[0] = '0;
    assign w_d_rem[1] = '0;
    assign w_d_num[0] = r6_nx;
    assign w_d_num[1] = r6_ny;

    olm_div_chain #(
        .LANES (2),
        .REM_W (W),
        .NUM_W (2 * W),
        .SIDE_W(FL_W)
    ) u_div_xy (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r6_v),
        .i_side (r6_f),
        .i_den  (r6_den),
        .i_rem  (w_d_rem),
        .i_num  (w_d_num),
        .o_valid(w_d_v),
        .o_side (w_d_side),
        .o_q    (w_d_q)
    );

    // Sign, offset and saturate
    t_flags                  w_fd;
    logic signed [2*W+1:0]   w_qx, w_qy, w_rx, w_ry;
    logic signed [2*W+1:0]   w_cx, w_cy;
    logic [W-1:0]            w_ox, w_oy;
    logic                    w_sat;
    t_status                 w_st;

    always_comb begin
        w_fd  = w_d_side;
        w_qx  = {2'b00, w_d_q[0]};
        w_qy  = {2'b00, w_d_q[1]};
        w_cx  = '0;
        w_cy  = '0;
        if (w_fd.act == ACT_PROJECT) begin
            w_cx = {{(W+2){r_center_x[W-1]}}, r_center_x};
            w_cy = {{(W+2){r_center_y[W-1]}}, r_center_y};
        end
        w_rx  = (w_fd.neg_x ? -w_qx : w_qx) + w_cx;
        w_ry  = (w_fd.neg_y ? -w_qy : w_qy) + w_cy;
        w_sat = 1'b0;
        w_ox  = w_rx[W-1:0];
        w_oy  = w_ry[W-1:0];
        if (w_rx > LIM_HI) begin
            w_ox  = LIM_HI[W-1:0];
            w_sat = 1'b1;
        end else if (w_rx < LIM_LO) begin
            w_ox  = LIM_LO[W-1:0];
            w_sat = 1'b1;
        end
        if (w_ry > LIM_HI) begin
            w_oy  = LIM_HI[W-1:0];
            w_sat = 1'b1;
        end else if (w_ry < LIM_LO) begin
            w_oy  = LIM_LO[W-1:0];
            w_sat = 1'b1;
        end
        w_st = w_sat ? ST_SAT : ST_OK;
        if (w_fd.outside) begin
            w_ox = '0;
            w_oy = '0;
            w_st = ST_OUTSIDE;
        end
    end

    // Output register and skid entry
    logic         r_ov, r_sv;
    logic [W-1:0] r_ox, r_oy, r_skx, r_sky;
    t_status      r_ost, r_skst;
    logic         w_push, w_pop;

    assign w_en   = !r_sv;
    assign w_push = w_en && w_d_v;
    assign w_pop  = r_ov && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_pop) begin
            if (r_sv) begin
                r_sv <= 1'b0;
            end else begin
                r_ov <= w_push;
            end
        end else if (w_push) begin
            if (r_ov) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && r_sv) begin
            r_ox  <= r_skx;
            r_oy  <= r_sky;
            r_ost <= r_skst;
        end else if (w_push && (w_pop || !r_ov)) begin
            r_ox  <= w_ox;
            r_oy  <= w_oy;
            r_ost <= w_st;
        end
        if (w_push && r_ov && !w_pop) begin
            r_skx  <= w_ox;
            r_sky  <= w_oy;
            r_skst <= w_st;
        end
    end

    assign o_valid  = r_ov;
    assign o_out_x  = r_ox;
    assign o_out_y  = r_oy;
    assign o_status = r_ost;
endmodule

// ===== design/olm_div_cell.sv =====
// One restoring division step: one quotient bit per enabled cycle.
module olm_div_cell #(
    parameter int REM_W = 32,
    parameter int NUM_W = 64
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [REM_W-1:0] i_rem,
    input  logic [NUM_W-1:0] i_nq,
    input  logic [REM_W-1:0] i_den,
    output logic [REM_W-1:0] o_rem,
    output logic [NUM_W-1:0] o_nq
);
    logic [REM_W:0]   w_t;
    logic [REM_W:0]   w_d;
    logic [REM_W:0]   w_diff;
    logic             w_ge;
    logic [REM_W-1:0] n_rem;
    logic [NUM_W-1:0] n_nq;
    logic [REM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_nq;

    always_comb begin
        w_t    = {i_rem, i_nq[NUM_W-1]};
        w_d    = {1'b0, i_den};
        w_ge   = (w_t >= w_d);
        w_diff = w_t - w_d;
        n_rem  = w_ge ? w_diff[REM_W-1:0] : w_t[REM_W-1:0];
        n_nq   = {i_nq[NUM_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
        end
    end

    assign o_rem = r_rem;
    assign o_nq  = r_nq;
endmodule

// ===== design/olm_div_chain.sv =====
// Row of division cells, several lanes sharing one divisor, with sideband.
module olm_div_chain #(
    parameter int LANES  = 1,
    parameter int REM_W  = 32,
    parameter int NUM_W  = 64,
    parameter int SIDE_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SIDE_W-1:0] i_side,
    input  logic [REM_W-1:0]  i_den,
    input  logic [REM_W-1:0]  i_rem [LANES],
    input  logic [NUM_W-1:0]  i_num [LANES],
    output logic              o_valid,
    output logic [SIDE_W-1:0] o_side,
    output logic [NUM_W-1:0]  o_q [LANES]
);
    logic [REM_W-1:0]  w_rem  [NUM_W+1][LANES];
    logic [NUM_W-1:0]  w_nq   [NUM_W+1][LANES];
    logic [REM_W-1:0]  w_den  [NUM_W+1];
    logic [SIDE_W-1:0] w_side [NUM_W+1];
    logic              w_v    [NUM_W+1];

    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;
    assign w_v[0]    = i_valid;

    for (genvar l = 0; l < LANES; l++) begin : g_in
        assign w_rem[0][l] = i_rem[l];
        assign w_nq[0][l]  = i_num[l];
        assign o_q[l]      = w_nq[NUM_W][l];
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              r_v;
        logic [REM_W-1:0]  r_den;
        logic [SIDE_W-1:0] r_side;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den  <= w_den[k];
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_den[k+1]  = r_den;
        assign w_side[k+1] = r_side;

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            olm_div_cell #(
                .REM_W(REM_W),
                .NUM_W(NUM_W)
            ) u_cell (
                .i_clk(i_clk),
                .i_en (i_en),
                .i_rem(w_rem[k][l]),
                .i_nq (w_nq[k][l]),
                .i_den(w_den[k]),
                .o_rem(w_rem[k+1][l]),
                .o_nq (w_nq[k+1][l])
            );
        end
    end

    assign o_valid = w_v[NUM_W];
    assign o_side  = w_side[NUM_W];
endmodule

// ===== design/olm_sqrt_cell.sv =====
// One digit-by-digit square root step: one root bit per enabled cycle.
module olm_sqrt_cell #(
    parameter int ROOT_W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ROOT_W+1:0]     i_rem,
    input  logic [ROOT_W-1:0]     i_root,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic [ROOT_W+1:0]     o_rem,
    output logic [ROOT_W-1:0]     o_root,
    output logic [2*ROOT_W-1:0]   o_rad
);
    logic [ROOT_W+3:0]   w_t;
    logic [ROOT_W+3:0]   w_trial;
    logic [ROOT_W+3:0]   w_diff;
    logic                w_ge;
    logic [ROOT_W+1:0]   n_rem;
    logic [ROOT_W-1:0]   n_root;
    logic [2*ROOT_W-1:0] n_rad;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [2*ROOT_W-1:0] r_rad;

    always_comb begin
        w_t     = {i_rem, i_rad[2*ROOT_W-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_ge    = (w_t >= w_trial);
        w_diff  = w_t - w_trial;
        n_rem   = w_ge ? w_diff[ROOT_W+1:0] : w_t[ROOT_W+1:0];
        n_root  = {i_root[ROOT_W-2:0], w_ge};
        n_rad   = {i_rad[2*ROOT_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
endmodule

// ===== design/olm_sqrt_chain.sv =====
// Row of square root cells with sideband, one root bit per cell.
module olm_sqrt_chain #(
    parameter int ROOT_W = 32,
    parameter int SIDE_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SIDE_W-1:0]   i_side,
    input  logic [2*ROOT_W-1:0] i_rad,
    output logic                o_valid,
    output logic [SIDE_W-1:0]   o_side,
    output logic [ROOT_W-1:0]   o_root
);
    logic [ROOT_W+1:0]   w_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]   w_root [ROOT_W+1];
    logic [2*ROOT_W-1:0] w_rad  [ROOT_W+1];
    logic [SIDE_W-1:0]   w_side [ROOT_W+1];
    logic                w_v    [ROOT_W+1];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = i_rad;
    assign w_side[0] = i_side;
    assign w_v[0]    = i_valid;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              r_v;
        logic [SIDE_W-1:0] r_side;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_side[k+1] = r_side;

        olm_sqrt_cell #(
            .ROOT_W(ROOT_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_rem (w_rem[k]),
            .i_root(w_root[k]),
            .i_rad (w_rad[k]),
            .o_rem (w_rem[k+1]),
            .o_root(w_root[k+1]),
            .o_rad (w_rad[k+1])
        );
    end

    assign o_valid = w_v[ROOT_W];
    assign o_side  = w_side[ROOT_W];
    assign o_root  = w_root[ROOT_W];
endmodule
